### src/b64d_pkg.sv
// Shared types, constants and the character lookup for the base64 stream decoder.
`timescale 1ns / 1ps
package b64d_pkg;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Work for the back end: up to three data bytes and an optional end report.
   typedef struct packed {
      logic [1:0] num_bytes;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic       has_end;
      logic [1:0] missing;
   } job_type;

   // Returns {in_alphabet, sextet value}.
   function automatic logic [6:0] sextet_lookup(input logic [7:0] ch);
      logic [6:0] res;
      res = 7'd0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         res = {1'b1, 6'(ch - 8'h41)};
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         res = {1'b1, 6'(ch - 8'h61 + 8'd26)};
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b1, 6'(ch - 8'h30 + 8'd52)};
      end else if (ch == CHAR_PLUS) begin
         res = {1'b1, 6'd62};
      end else if (ch == CHAR_SLASH) begin
         res = {1'b1, 6'd63};
      end
      return res;
   endfunction

endpackage

### src/b64d_front.sv
// Front end: classifies each character, keeps the group state and builds result jobs.
`timescale 1ns / 1ps
module b64d_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                char_valid,
   input  logic [7:0]          char_code,
   input  logic                last_char,
   output logic                job_push,
   output b64d_pkg::job_type   job
);
   import b64d_pkg::*;

   logic [17:0] sextet_ff, sextet_in;
   logic [1:0]  count_ff, count_in;
   logic        stopped_ff, stopped_in;
   logic [6:0]  lookup;
   logic [23:0] word;

   assign lookup = sextet_lookup(char_code);
   assign word   = {sextet_ff, lookup[5:0]};

   always_comb begin
      sextet_in   = sextet_ff;
      count_in    = count_ff;
      stopped_in  = stopped_ff;
      job         = '0;
      if (!stopped_ff) begin
         if (lookup[6]) begin
            if (count_ff == 2'd3) begin
               job.num_bytes = 2'd3;
               job.byte0     = word[23:16];
               job.byte1     = word[15:8];
               job.byte2     = word[7:0];
               sextet_in     = '0;
               count_in      = 2'd0;
            end else begin
               sextet_in = {sextet_ff[11:0], lookup[5:0]};
               count_in  = count_ff + 2'd1;
            end
         end else begin
            stopped_in = 1'b1;
            if (char_code == CHAR_PAD) begin
               if (count_ff == 2'd2) begin
                  job.num_bytes = 2'd1;
                  job.byte0     = sextet_ff[11:4];
               end else if (count_ff == 2'd3) begin
                  job.num_bytes = 2'd2;
                  job.byte0     = sextet_ff[17:10];
                  job.byte1     = sextet_ff[9:2];
               end
            end
         end
      end
      if (last_char) begin
         // four minus the count, wrapping to zero for an empty group
         job.has_end = 1'b1;
         job.missing = 2'd0 - count_in;
         sextet_in   = '0;
         count_in    = 2'd0;
         stopped_in  = 1'b0;
      end
   end

   assign job_push = char_valid && (job.has_end || job.num_bytes != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         sextet_ff  <= '0;
         count_ff   <= 2'd0;
         stopped_ff <= 1'b0;
      end else if (char_valid) begin
         sextet_ff  <= sextet_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

### src/b64d_queue.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module b64d_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64d_pkg::job_type   push_job,
   input  logic                pop,
   output logic                not_empty,
   output logic                not_full,
   output b64d_pkg::job_type   head_job
);
   import b64d_pkg::*;

   job_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign not_empty = count_ff != '0;
   assign not_full  = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

### src/b64d_back.sv
// Back end: unrolls each job into result items through an output register.
`timescale 1ns / 1ps
module b64d_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  b64d_pkg::job_type   job,
   output logic                job_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,
   output logic [0:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import b64d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff;
   logic       kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] missing_ff, missing_in;
   logic       last_ff, last_in;
   logic [2:0] total;
   logic       load;

   assign total = {1'b0, job.num_bytes} + {2'b00, job.has_end};
   assign load  = job_valid && (!valid_ff || rsp_tready);

   always_comb begin
      kind_in    = KIND_DATA;
      byte_in    = 8'd0;
      missing_in = 2'd0;
      if (idx_ff == job.num_bytes) begin
         kind_in    = KIND_END;
         missing_in = job.missing;
      end else begin
         case (idx_ff)
            2'd0:    byte_in = job.byte0;
            2'd1:    byte_in = job.byte1;
            default: byte_in = job.byte2;
         endcase
      end
      last_in = ({1'b0, idx_ff} + 3'd1) == total;
      idx_in  = last_in ? 2'd0 : idx_ff + 2'd1;
   end

   assign job_pop = load && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         byte_ff    <= byte_in;
         missing_ff <= missing_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, missing_ff, byte_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

### src/base64_stream_decoder_core.sv
// Top level of the base64 stream decoder.
`timescale 1ns / 1ps
// Usage:
//   The request channel (req_*) carries one character per beat: tdata[7:0]
//   is the raw character, tlast marks the final character of a string.
//   The response channel (rsp_*) carries decoded results: tuser is the kind
//   (0 data byte, 1 end-of-string report), tdata[7:0] the data byte,
//   tdata[9:8] the number of characters missing from the last group, and
//   tlast marks the final result caused by one request.
//   A request is taken every cycle while the four-entry job queue has room;
//   a full group yields three results, drained one per cycle by the output
//   register while the receiver is ready; sustained input is one character
//   per cycle. Results pass through the job queue, then the output register.
//   When the receiver stalls, the output register holds its result and the
//   queue absorbs up to four result-producing requests before req_tready
//   falls. Requests that produce no result pass without using the queue.
//   Synchronous reset clears the group state, the queue and the output.
module base64_stream_decoder_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] char_code
   input  logic         req_tlast,   // last_char
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // [7:0] data_byte, [9:8] missing_chars, rest zero
   output logic [0:0]   rsp_tuser,   // [0] result_kind
   output logic         rsp_tlast    // last_result
);
   import b64d_pkg::*;

   logic    accept;
   logic    job_push;
   job_type push_job;
   logic    q_not_empty;
   logic    q_not_full;
   job_type head_job;
   logic    job_pop;

   assign req_tready = q_not_full;
   assign accept     = req_tvalid && req_tready;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .char_valid (accept),
      .char_code  (req_tdata),
      .last_char  (req_tlast),
      .job_push   (job_push),
      .job        (push_job)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .not_empty (q_not_empty),
      .not_full  (q_not_full),
      .head_job  (head_job)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_not_empty),
      .job        (head_job),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the base64 stream decoder core.
`timescale 1ns / 1ps
module tb;
   import b64d_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 110;

   typedef struct packed {
      logic [7:0] ch;
      logic       last_char;
   } char_item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [1:0] missing;
      logic       final_flag;
   } dec_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;   // [7:0] char_code
   logic         req_tlast = 1'b0;   // last_char
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;          // [7:0] data_byte, [9:8] missing_chars
   logic [0:0]   rsp_tuser;          // [0] result_kind
   logic         rsp_tlast;          // last_result

   base64_stream_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   char_item_type  char_q[$];
   dec_result_type decode_results_q[$];
   char_item_type  next_char;
   dec_result_type want;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  pushed_count = 0;
   int  accepted_count = 0;
   int  fail_count = 0;
   int  quiet_cycles = 0;
   int  hold_asked = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;

   // Decoder state as seen by the predictor.
   logic [17:0] sextets = '0;
   logic [1:0]  grp_cnt = '0;
   logic        halted = 1'b0;

   // {in_alphabet, value}
   function automatic logic [6:0] char_sextet(input logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return {1'b1, 6'(ch - "A")};
      if (ch >= "a" && ch <= "z") return {1'b1, 6'(ch - "a" + 26)};
      if (ch >= "0" && ch <= "9") return {1'b1, 6'(ch - "0" + 52)};
      if (ch == CHAR_PLUS) return {1'b1, 6'd62};
      if (ch == CHAR_SLASH) return {1'b1, 6'd63};
      return 7'd0;
   endfunction

   function automatic logic [7:0] alpha_char(input int unsigned v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      if (v == 62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function automatic dec_result_type data_result(input logic [7:0] b);
      return '{kind: KIND_DATA, data_byte: b, missing: 2'd0, final_flag: 1'b0};
   endfunction

   task automatic decode_char(input logic [7:0] ch, input logic last_char);
      logic [6:0]     hit_val;
      logic [23:0]    word;
      dec_result_type out[$];
      if (!halted) begin
         hit_val = char_sextet(ch);
         if (hit_val[6]) begin
            if (grp_cnt == 2'd3) begin
               word = {sextets, hit_val[5:0]};
               out.insert(out.size(), data_result(word[23:16]));
               out.insert(out.size(), data_result(word[15:8]));
               out.insert(out.size(), data_result(word[7:0]));
               sextets = '0;
               grp_cnt = '0;
            end else begin
               sextets = {sextets[11:0], hit_val[5:0]};
               grp_cnt = grp_cnt + 2'd1;
            end
         end else begin
            halted = 1'b1;
            if (ch == CHAR_PAD) begin
               if (grp_cnt == 2'd2) begin
                  out.insert(out.size(), data_result(sextets[11:4]));
               end else if (grp_cnt == 2'd3) begin
                  out.insert(out.size(), data_result(sextets[17:10]));
                  out.insert(out.size(), data_result(sextets[9:2]));
               end
            end
         end
      end
      if (last_char) begin
         // 4 - n wraps to 0 for an empty group in two bits
         out.insert(out.size(), '{kind: KIND_END, data_byte: 8'd0,
                                  missing: 2'd0 - grp_cnt, final_flag: 1'b0});
         sextets = '0;
         grp_cnt = '0;
         halted = 1'b0;
      end
      if (out.size() > 0) out[out.size() - 1].final_flag = 1'b1;
      foreach (out[i]) decode_results_q.insert(decode_results_q.size(), out[i]);
   endtask

   // Driver: present the next request once the current one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_char = char_q.pop_front();
            req_tdata  <= next_char.ch;
            req_tlast  <= next_char.last_char;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver backpressure, with a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left == 0 && hold_served != hold_asked) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Monitor: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      rsp_taken = !reset && rsp_tvalid && rsp_tready;
      if (req_taken) begin
         decode_char(req_tdata, req_tlast);
         accepted_count++;
      end
      if (rsp_taken) begin
         if (decode_results_q.size() == 0) begin
            $error("result with nothing pending: kind %0d tdata %h last %0d",
                   rsp_tuser[0], rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = decode_results_q.pop_front();
            if (rsp_tuser[0] !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tdata[7:0] !== want.data_byte) begin
               $error("data_byte: expected %h, got %h", want.data_byte, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[9:8] !== want.missing) begin
               $error("missing_chars: expected %0d, got %0d", want.missing, rsp_tdata[9:8]);
               fail_count++;
            end
            if (rsp_tlast !== want.final_flag) begin
               $error("last_result: expected %0d, got %0d", want.final_flag, rsp_tlast);
               fail_count++;
            end
         end
      end
      if (req_taken || rsp_taken) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic push_string(input logic [7:0] chars[$]);
      foreach (chars[i]) begin
         char_q.insert(char_q.size(), '{ch: chars[i], last_char: (i == chars.size() - 1)});
         pushed_count++;
      end
   endtask

   task automatic push_text(input string s);
      logic [7:0] chars[$];
      for (int i = 0; i < s.len(); i++) chars.insert(chars.size(), s[i]);
      push_string(chars);
   endtask

   // Strings with random content, some well-formed and the rest broken or noise.
   task automatic push_random_string(output int n_items);
      logic [7:0] chars[$];
      int groups;
      int tail;
      int k;
      groups = $urandom_range(0, 3);
      repeat (groups * 4) chars.insert(chars.size(), alpha_char($urandom_range(63)));
      tail = $urandom_range(9);
      case (tail)
         2: begin
            repeat (2) chars.insert(chars.size(), alpha_char($urandom_range(63)));
            repeat (2) chars.insert(chars.size(), CHAR_PAD);
         end
         3: begin
            repeat (2) chars.insert(chars.size(), alpha_char($urandom_range(63)));
            chars.insert(chars.size(), CHAR_PAD);
         end
         4: begin
            repeat (3) chars.insert(chars.size(), alpha_char($urandom_range(63)));
            chars.insert(chars.size(), CHAR_PAD);
         end
         5: begin
            repeat ($urandom_range(0, 1))
               chars.insert(chars.size(), alpha_char($urandom_range(63)));
            chars.insert(chars.size(), CHAR_PAD);
         end
         6: begin
            repeat ($urandom_range(1, 3))
               chars.insert(chars.size(), alpha_char($urandom_range(63)));
         end
         7: begin
            k = $urandom_range(chars.size());
            chars.insert(k, 8'($urandom_range(255)));
            repeat ($urandom_range(0, 3))
               chars.insert(chars.size(), alpha_char($urandom_range(63)));
         end
         8: begin
            chars.insert(chars.size(), CHAR_PAD);
            repeat ($urandom_range(1, 4)) chars.insert(chars.size(), 8'($urandom_range(255)));
         end
         9: begin
            repeat ($urandom_range(1, 4)) chars.insert(chars.size(), 8'($urandom_range(255)));
         end
         default: begin
         end
      endcase
      if (chars.size() == 0) chars.insert(chars.size(), alpha_char($urandom_range(63)));
      push_string(chars);
      n_items = chars.size();
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_count != pushed_count || decode_results_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int phase_items;
      int n;
      logic [7:0] chars[$];
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      @(posedge clock);
      push_text("//+/");
      push_text("TWE=");
      push_text("TQ=");
      push_text("T=");
      push_text("=Z");
      push_text("TWF");
      chars = '{8'hFF, "A"};
      push_string(chars);
      chars = '{8'h00};
      push_string(chars);
      wait_drained();

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 9;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         @(posedge clock);
         if (p != 1) hold_asked++;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            push_random_string(n);
            phase_items += n;
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
